/* sv/assert_macros.svh */
// assertion macros used by the rtl of the grid pooling block
// depends on: nothing; the including module must have clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge out of reset
`define GP2_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("grid pool assertion failed");

// antecedent in one cycle implies consequent in the next
`define GP2_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid pool assertion failed");

`else

`define GP2_ASSERT_ALWAYS(lbl, prop)
`define GP2_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/gp2_pkg.sv */
// constants, derived widths and register codes of the grid pooling block
// depends on: nothing
package gp2_pkg;

	// widest row the line buffer supports
	localparam int MAX_WIDTH = 1024;
	// one line buffer entry per horizontal pair
	localparam int STORE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	// column position holds 0 .. MAX_WIDTH-1
	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	// effective width holds 2 .. MAX_WIDTH
	localparam int EFF_W = $clog2(MAX_WIDTH + 1);

	// fixed field widths
	localparam int CELL_W = 8;
	localparam int PAIR_W = 9;
	localparam int GW_W = 11;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_POOL_MODE  = 1'b0,
		REG_GRID_WIDTH = 1'b1
	} reg_index_t;

	// pooling modes
	typedef enum logic {
		MODE_AVG = 1'b0,
		MODE_MAX = 1'b1
	} pool_mode_t;

	localparam logic [GW_W-1:0] GRID_WIDTH_RST = 11'd1024;

endpackage

/* sv/grid_pool_2x2.sv */
// top level of the 2x2 stride-2 pooling block (average or maximum)
// depends on: gp2_pkg, gp2_ram, assert_macros.svh
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------
//  in      | in_valid / in_stall      | cell_req, frame_end
//  out     | out_valid / out_stall    | pooled, row_end
//  config  | wr_en                    | wr_index, wr_data
//
// one item per cycle sustained unless out_stall backs up into in_stall; a pooled
// cell passes from the item that completes its block through the line buffer's
// registered read and the read stage, then into the output register.
// reset clears position, row parity and valids, not the line buffer; a top
// row writes its pairs before a bottom row reads them, unless the width grows in between.
// out_stall holds the output register and the read stage; in_stall rises
// only when the read stage is full and cannot drain.
`include "assert_macros.svh"

module grid_pool_2x2 (
	input  logic                        clk,
	input  logic                        arst_n,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [7:0]           cell_req,
	input  logic                        frame_end,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [7:0]           pooled,
	output logic                        row_end,
	// configuration writes
	input  logic                        wr_en,
	input  logic [0:0]                  wr_index,
	input  logic [10:0]                 wr_data
);

	localparam int MaxWidth = gp2_pkg::MAX_WIDTH;
	localparam int StoreDepth = gp2_pkg::STORE_DEPTH;
	localparam int IdxW = gp2_pkg::IDX_W;
	localparam int ColW = gp2_pkg::COL_W;
	localparam int EffW = gp2_pkg::EFF_W;
	localparam int GwW = gp2_pkg::GW_W;
	localparam int PairW = gp2_pkg::PAIR_W;
	localparam int CellW = gp2_pkg::CELL_W;
	localparam int CmpW = (EffW > GwW) ? EffW : GwW;

	// configuration registers
	gp2_pkg::pool_mode_t   pool_mode_q;
	logic [GwW-1:0]        grid_width_q;

	// position state
	logic [ColW-1:0]           col_q;
	logic                      row_odd_q;
	logic signed [CellW-1:0]   left_cell_q;

	// read stage and output register
	logic                      s1_valid_q;
	logic signed [PairW-1:0]   pair_s1;
	logic                      row_end_s1;
	logic                      out_valid_q;
	logic signed [CellW-1:0]   pooled_q;
	logic                      row_end_q;

	// combinational
	logic [CmpW-1:0]           gw_ext;
	logic [EffW-1:0]           eff_w;
	logic [EffW-1:0]           col_ext;
	logic                      in_row;
	logic                      is_pair_end;
	logic                      emit;
	logic                      store_wr;
	logic                      accept;
	logic                      adv_out;
	logic                      last_col;
	logic                      row_end_now;
	logic [ColW-1:0]           half_col;
	logic [IdxW-1:0]           store_idx;
	logic signed [PairW-1:0]   pair_now;
	logic signed [PairW-1:0]   top_rd;
	logic [PairW-1:0]          store_rdata;
	logic signed [PairW:0]     sum4;
	logic signed [PairW:0]     sum4_biased;
	logic signed [PairW:0]     avg4;
	logic signed [PairW-1:0]   max4;
	logic signed [CellW-1:0]   result;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_mode_q  <= gp2_pkg::MODE_AVG;
			grid_width_q <= gp2_pkg::GRID_WIDTH_RST;
		end else if (wr_en) begin
			unique case (gp2_pkg::reg_index_t'(wr_index))
				gp2_pkg::REG_POOL_MODE: begin
					pool_mode_q <= gp2_pkg::pool_mode_t'(wr_data[0]);
				end
				gp2_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= wr_data;
				end
			endcase
		end
	end

	// effective width clamped to 2 .. MAX_WIDTH
	always_comb begin
		gw_ext = CmpW'(grid_width_q);
		if (gw_ext < CmpW'(2)) begin
			eff_w = EffW'(2);
		end else if (gw_ext > CmpW'(MaxWidth)) begin
			eff_w = EffW'(MaxWidth);
		end else begin
			eff_w = gw_ext[EffW-1:0];
		end
	end

	// position decode
	always_comb begin
		col_ext     = EffW'(col_q);
		in_row      = col_ext < eff_w;
		is_pair_end = in_row && col_q[0];
		emit        = is_pair_end && row_odd_q;
		store_wr    = is_pair_end && !row_odd_q;
		last_col    = (col_ext + EffW'(1)) >= eff_w;
		row_end_now = ((EffW + 1)'(col_ext) + (EffW + 1)'(2)) > (EffW + 1)'(eff_w);
		half_col    = col_q >> 1;
		if (half_col >= ColW'(StoreDepth)) begin
			store_idx = IdxW'(half_col - ColW'(StoreDepth));
		end else begin
			store_idx = IdxW'(half_col);
		end
	end

	// horizontal pair: sum or maximum of left and current cell
	always_comb begin
		if (pool_mode_q == gp2_pkg::MODE_MAX) begin
			pair_now = (left_cell_q > cell_req) ? PairW'(left_cell_q) : PairW'(cell_req);
		end else begin
			pair_now = PairW'(left_cell_q) + PairW'(cell_req);
		end
	end

	// handshake
	assign adv_out  = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !adv_out;
	assign accept   = in_valid && !in_stall;

	// line buffer of top-row pair values; writes and reads never share a cycle
	gp2_ram #(
		.WIDTH (PairW),
		.DEPTH (StoreDepth)
	) u_store (
		.clk   (clk),
		.we    (accept && store_wr),
		.re    (accept && emit),
		.addr  (store_idx),
		.wdata (pair_now),
		.rdata (store_rdata)
	);

	// position, row parity and left cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_odd_q   <= 1'b0;
			left_cell_q <= '0;
		end else if (accept) begin
			if (in_row && !col_q[0]) begin
				left_cell_q <= cell_req;
			end
			if (frame_end) begin
				col_q     <= '0;
				row_odd_q <= 1'b0;
			end else if (last_col) begin
				col_q     <= '0;
				row_odd_q <= !row_odd_q;
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	// read stage: waits for the line buffer data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pair_s1    <= pair_now;
			row_end_s1 <= row_end_now;
		end
	end

	// combine top pair with bottom pair
	always_comb begin
		top_rd      = store_rdata;
		sum4        = (PairW + 1)'(top_rd) + (PairW + 1)'(pair_s1);
		sum4_biased = sum4 + (sum4[PairW] ? (PairW + 1)'(3) : (PairW + 1)'(0));
		avg4        = sum4_biased >>> 2;
		max4        = (top_rd > pair_s1) ? top_rd : pair_s1;
		if (pool_mode_q == gp2_pkg::MODE_MAX) begin
			if (max4 > PairW'(127)) begin
				result = CellW'(127);
			end else if (max4 < -PairW'(128)) begin
				result = -CellW'(128);
			end else begin
				result = max4[CellW-1:0];
			end
		end else begin
			result = avg4[CellW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && s1_valid_q) begin
			pooled_q  <= result;
			row_end_q <= row_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pooled    = pooled_q;
	assign row_end   = row_end_q;

	// checks
	`GP2_ASSERT_ALWAYS(a_stall_needs_full_s1, in_stall |-> s1_valid_q)
	`GP2_ASSERT_NEXT(a_emit_fills_s1, accept && emit, s1_valid_q)
	`GP2_ASSERT_NEXT(a_s1_drains_to_out, s1_valid_q && adv_out, out_valid_q)
	`GP2_ASSERT_NEXT(a_frame_end_rewinds, accept && frame_end, col_q == '0 && !row_odd_q)

endmodule

/* sv/gp2_ram.sv */
// generic single-port synchronous ram with registered read data
// depends on: nothing
module gp2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
	input  logic [WIDTH-1:0]                              wdata,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read, data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* verif/tb_grid_pool_2x2.sv */
// self-checking testbench of grid_pool_2x2: 2x2 stride-2 average and maximum pooling
// depends on: gp2_pkg and the grid_pool_2x2 rtl; a class tracks the pooled cells it expects
// drives directed blocks, random frames under random width and mode, then one frame without idling
module tb_grid_pool_2x2;
	timeunit 1ns;
	timeprecision 1ps;

	// one pooled cell as it leaves the block
	typedef struct {
		logic signed [gp2_pkg::CELL_W-1:0] value;
		logic                              last;
	} pooled_cell_t;

	// shapes of a random frame
	typedef enum int {
		FRAME_WHOLE,
		FRAME_BROKEN,
		FRAME_OPEN,
		FRAME_RETUNE
	} frame_kind_t;

	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_CELLS = 360;
	localparam int LAST_WIDTH = 24;
	localparam int LAST_ROWS = 4;

	// tracks position, line buffer and registers; predicts and checks pooled cells
	class pool_tracker_t;
		gp2_pkg::pool_mode_t               mode = gp2_pkg::MODE_AVG;
		logic [gp2_pkg::GW_W-1:0]          width_reg = gp2_pkg::GRID_WIDTH_RST;
		int                                col = 0;
		logic                              row_odd = 1'b0;
		logic signed [gp2_pkg::CELL_W-1:0] left = '0;
		logic signed [gp2_pkg::PAIR_W-1:0] pair_mem [gp2_pkg::STORE_DEPTH];
		pooled_cell_t                      pending_pools[$];
		int                                n_cells = 0;
		int                                n_checked = 0;
		int                                fails = 0;

		function int clamp_width(logic [gp2_pkg::GW_W-1:0] g);
			if (g < 2)
				return 2;
			if (g > gp2_pkg::MAX_WIDTH)
				return gp2_pkg::MAX_WIDTH;
			return int'(g);
		endfunction

		function int width_now();
			return clamp_width(width_reg);
		endfunction

		function void set_reg(logic [0:0] idx, logic [gp2_pkg::GW_W-1:0] d);
			if (gp2_pkg::reg_index_t'(idx) == gp2_pkg::REG_POOL_MODE)
				mode = gp2_pkg::pool_mode_t'(d[0]);
			else
				width_reg = d;
		endfunction

		// one accepted cell: update the line buffer, queue a pooled cell on a bottom pair
		function void note_cell(logic signed [gp2_pkg::CELL_W-1:0] c, logic fend);
			int w;
			int lft;
			int cur;
			int pair;
			int top;
			int res;
			pooled_cell_t e;
			w = width_now();
			lft = left;
			cur = c;
			n_cells++;
			if (col < w) begin
				if (col % 2 == 0) begin
					left = c;
				end else begin
					pair = (mode == gp2_pkg::MODE_MAX) ? ((lft > cur) ? lft : cur) : lft + cur;
					if (!row_odd) begin
						pair_mem[col / 2] = gp2_pkg::PAIR_W'(pair);
					end else begin
						top = pair_mem[col / 2];
						if (mode == gp2_pkg::MODE_MAX) begin
							res = (top > pair) ? top : pair;
							// a stored sum can exceed the cell range
							if (res > 127)
								res = 127;
							if (res < -128)
								res = -128;
						end else begin
							res = (top + pair) / 4;
						end
						e.value = gp2_pkg::CELL_W'(res);
						e.last = (col + 2 > w);
						pending_pools = {pending_pools, e};
					end
				end
			end
			// advance position, wrap at the row end, restart on frame end
			if (col + 1 >= w) begin
				col = 0;
				row_odd = ~row_odd;
			end else begin
				col = col + 1;
			end
			if (fend) begin
				col = 0;
				row_odd = 1'b0;
			end
		endfunction

		// one accepted pooled cell against the oldest one expected
		function void check_pooled(logic signed [gp2_pkg::CELL_W-1:0] v, logic last);
			pooled_cell_t e;
			if (pending_pools.size() == 0) begin
				fails++;
				$display("%0t: expected no pooled cell, got %0d row_end %0b", $time, v, last);
				return;
			end
			e = pending_pools.pop_front();
			n_checked++;
			if (v !== e.value) begin
				fails++;
				$display("%0t: pooled expected %0d, got %0d", $time, e.value, v);
			end
			if (last !== e.last) begin
				fails++;
				$display("%0t: row_end expected %0b, got %0b", $time, e.last, last);
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic signed [gp2_pkg::CELL_W-1:0] cell_req;
	logic                              frame_end;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [gp2_pkg::CELL_W-1:0] pooled;
	logic                              row_end;
	logic                              wr_en;
	logic [0:0]                        wr_index;
	logic [gp2_pkg::GW_W-1:0]          wr_data;

	pool_tracker_t sb = new();
	bit            quiet = 1'b0;
	int            gap_odds = 4;
	int            sent = 0;

	grid_pool_2x2 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cell_req  (cell_req),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pooled    (pooled),
		.row_end   (row_end),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watch every handshake and register write
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				sb.set_reg(wr_index, wr_data);
			if (in_valid && !in_stall)
				sb.note_cell(cell_req, frame_end);
			if (out_valid && !out_stall)
				sb.check_pooled(pooled, row_end);
		end
	end

	// result side: random stall bursts, long open stretches now and then
	initial begin : sink
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1'b1;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
				out_stall <= 1'b0;
			end
			repeat (n) @(posedge clk);
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb_grid_pool_2x2: FAIL");
		$finish;
	end

	// one cell, after an optional idle burst; returns at the accepting edge
	task automatic send_cell(input logic signed [gp2_pkg::CELL_W-1:0] c, input logic fend);
		int n;
		if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			n = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_req <= c;
		frame_end <= fend;
		sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the input until every pooled cell is out, then let the pipeline empty
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_pools.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input gp2_pkg::reg_index_t idx,
			input logic [gp2_pkg::GW_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// random mode and width; call only with the block idle
	task automatic retune();
		logic [gp2_pkg::GW_W-1:0] w;
		if ($urandom_range(0, 1))
			write_reg(gp2_pkg::REG_POOL_MODE, gp2_pkg::GW_W'($urandom_range(0, 1)));
		case ($urandom_range(0, 19))
			0: w = gp2_pkg::GW_W'($urandom_range(0, 1));
			1: w = gp2_pkg::GW_W'($urandom_range(13, 48));
			default: w = gp2_pkg::GW_W'($urandom_range(2, 12));
		endcase
		// a wider row may start only on a top row, else a bottom row reads unwritten pairs
		if (sb.clamp_width(w) <= sb.width_now() || !sb.row_odd)
			write_reg(gp2_pkg::REG_GRID_WIDTH, w);
	endtask

	// a frame of rows at the current width, whole or cut short or left open
	task automatic run_frame(input int rows, input frame_kind_t kind);
		int total;
		int cut;
		int mid;
		logic signed [gp2_pkg::CELL_W-1:0] c;
		total = sb.width_now() * rows;
		cut = (kind == FRAME_BROKEN) ? $urandom_range(0, total - 1) : total - 1;
		mid = (kind == FRAME_RETUNE) ? $urandom_range(1, total - 1) : -1;
		for (int k = 0; k <= cut; k++) begin
			if (k == mid) begin
				drain_and_settle();
				retune();
			end
			case ($urandom_range(0, 9))
				0: c = 8'sh7f;
				1: c = 8'sh80;
				default: c = gp2_pkg::CELL_W'($urandom_range(0, 255));
			endcase
			send_cell(c, (k == cut) && (kind != FRAME_OPEN));
		end
	endtask

	initial begin
		int start;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cell_req <= '0;
		frame_end <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= gp2_pkg::REG_POOL_MODE;
		wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// width below range clamps to two: each 2x2 block stands alone
		write_reg(gp2_pkg::REG_GRID_WIDTH, gp2_pkg::GW_W'(0));
		write_reg(gp2_pkg::REG_POOL_MODE, gp2_pkg::GW_W'(gp2_pkg::MODE_AVG));
		// all cells at the top and at the bottom of the range
		send_cell(8'sh7f, 1'b0);
		send_cell(8'sh7f, 1'b0);
		send_cell(8'sh7f, 1'b0);
		send_cell(8'sh7f, 1'b1);
		send_cell(8'sh80, 1'b0);
		send_cell(8'sh80, 1'b0);
		send_cell(8'sh80, 1'b0);
		send_cell(8'sh80, 1'b0);
		// negative sum truncates toward zero
		send_cell(-8'sd1, 1'b0);
		send_cell(-8'sd1, 1'b0);
		send_cell(-8'sd1, 1'b0);
		send_cell(8'sd0, 1'b1);
		// top pair stored as a sum, bottom pair under maximum: saturates high
		send_cell(8'sh7f, 1'b0);
		send_cell(8'sh7f, 1'b0);
		drain_and_settle();
		write_reg(gp2_pkg::REG_POOL_MODE, gp2_pkg::GW_W'(gp2_pkg::MODE_MAX));
		send_cell(8'sh80, 1'b0);
		send_cell(8'sh80, 1'b0);
		// top pair stored as a maximum, bottom pair under average
		send_cell(8'sh7f, 1'b0);
		send_cell(-8'sd3, 1'b0);
		drain_and_settle();
		write_reg(gp2_pkg::REG_POOL_MODE, gp2_pkg::GW_W'(gp2_pkg::MODE_AVG));
		send_cell(8'sh7f, 1'b0);
		send_cell(8'sh7f, 1'b0);
		// width shrinks mid-row: the cell past the new width is dropped
		drain_and_settle();
		write_reg(gp2_pkg::REG_GRID_WIDTH, gp2_pkg::GW_W'(4));
		send_cell(8'sd40, 1'b0);
		send_cell(-8'sd17, 1'b0);
		send_cell(8'sd9, 1'b0);
		drain_and_settle();
		write_reg(gp2_pkg::REG_GRID_WIDTH, gp2_pkg::GW_W'(2));
		send_cell(8'sd100, 1'b0);
		send_cell(-8'sd50, 1'b0);
		send_cell(8'sd33, 1'b1);

		// random frames, retuned between frames about half the time
		start = sent;
		while (sent - start < RANDOM_CELLS) begin
			case ($urandom_range(0, 3))
				0: gap_odds = 0;
				1: gap_odds = 3;
				2: gap_odds = 8;
				default: gap_odds = 20;
			endcase
			if ($urandom_range(0, 1)) begin
				drain_and_settle();
				retune();
			end
			case ($urandom_range(0, 9))
				0: run_frame($urandom_range(1, 5), FRAME_BROKEN);
				1: run_frame($urandom_range(1, 5), FRAME_OPEN);
				2, 3: run_frame($urandom_range(1, 5), FRAME_RETUNE);
				default: run_frame($urandom_range(1, 5), FRAME_WHOLE);
			endcase
		end

		// close an open frame so the wider rows below start from a top row
		drain_and_settle();
		if (sb.row_odd || sb.col != 0) begin
			send_cell(8'sd0, 1'b1);
			drain_and_settle();
		end

		// last frame, no idling on either side
		quiet = 1'b1;
		write_reg(gp2_pkg::REG_POOL_MODE, gp2_pkg::GW_W'(gp2_pkg::MODE_MAX));
		write_reg(gp2_pkg::REG_GRID_WIDTH, gp2_pkg::GW_W'(LAST_WIDTH));
		run_frame(LAST_ROWS, FRAME_WHOLE);
		drain_and_settle();

		$display("ran %0d cells, %0d pooled cells checked, %0d failures", sb.n_cells,
			sb.n_checked, sb.fails);
		$display("covered both modes, clamped and narrow to mid widths, mid-row retunes");
		if (sb.fails == 0)
			$display("tb_grid_pool_2x2: PASS");
		else
			$display("tb_grid_pool_2x2: FAIL");
		$finish;
	end
endmodule

/* grid_pool_2x2.f */
+incdir+sv
sv/gp2_pkg.sv
sv/gp2_ram.sv
sv/grid_pool_2x2.sv
verif/tb_grid_pool_2x2.sv
